@@ rtl/core/ldr_pkg.sv @@
// Shared types, constants and fixed-point helpers for the lens distortion remap.
package ldr_pkg;

  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 24;
  localparam int CoordW    = 10;
  localparam int QW        = 32;
  localparam int FracW     = 20;
  localparam int DivSteps  = 32;
  localparam int DivLat    = DivSteps + 2;
  localparam int DivRemW   = CfgDataW + FracW;
  localparam int ImageWidthDef  = 1024;
  localparam int ImageHeightDef = 1024;

  localparam logic [CfgDataW-1:0] FocalReset  = 24'd131072;
  localparam logic [CfgDataW-1:0] CenterReset = 24'd131072;
  localparam logic signed [QW-1:0] OneQ20 = 32'sd1048576;
  localparam logic signed [QW-1:0] SatMax = 32'sh7FFFFFFF;
  localparam logic signed [QW-1:0] SatMin = 32'sh80000001;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FOCAL_X  = 4'd0,
    REG_FOCAL_Y  = 4'd1,
    REG_CENTER_X = 4'd2,
    REG_CENTER_Y = 4'd3,
    REG_K1       = 4'd4,
    REG_K2       = 4'd5,
    REG_P1       = 4'd6,
    REG_P2       = 4'd7
  } cfg_reg_e;

  // Clamp to the symmetric signed 32-bit range
  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return SatMax;
    end else if (v < -64'sd2147483647) begin
      return SatMin;
    end
    return v[QW-1:0];
  endfunction

  // Q20 product with floor rounding, then clamp
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> FracW);
  endfunction

endpackage

@@ rtl/core/lens_distortion_remap.sv @@
// Top level: radial-tangential undistort remap, output pixel to source pixel.
//
// Input channel (in_valid_i/in_ready_o) carries an output pixel coordinate;
// output channel (out_valid_o/out_ready_i) returns the truncated source
// column and row plus in_range (clear means zero-fill, coordinates zero).
// Configuration channel writes intrinsics and coefficients by index;
// it is always ready and must only be used while the pipeline is empty.
// The pipeline is a 34-stage normalizing divider (one quotient bit per
// step stage per axis) followed by 9 multiply/add stages.
// Throughput is one transaction per cycle. The whole pipeline advances
// together; when the output holds a result the receiver has not taken,
// every stage freezes and in_ready_o drops until out_ready_i returns.
// Reset clears all valid bits and loads focal lengths and the principal
// point with 512.0 and the distortion coefficients with zero.
module lens_distortion_remap import ldr_pkg::*; #(
  parameter int IMAGE_WIDTH  = ImageWidthDef,
  parameter int IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CoordW-1:0]    out_col_i,
  input  logic [CoordW-1:0]    out_row_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CoordW-1:0]    src_col_o,
  output logic [CoordW-1:0]    src_row_o,
  output logic                 in_range_o
);

  localparam int Last = DivLat + 8;
  localparam logic signed [57:0] ColLimit = 58'(IMAGE_WIDTH) <<< 28;
  localparam logic signed [57:0] RowLimit = 58'(IMAGE_HEIGHT) <<< 28;

  logic [CfgDataW-1:0] fx_q, fy_q, cx_q, cy_q;
  logic signed [CfgDataW-1:0] k1_q, k2_q, p1_q, p2_q;
  logic signed [QW-1:0] k1, k2, p1, p2;

  logic              en;
  logic [Last:0]     vld_q;
  logic signed [QW-1:0] x_w, y_w;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= FocalReset;
      fy_q <= FocalReset;
      cx_q <= CenterReset;
      cy_q <= CenterReset;
      k1_q <= '0;
      k2_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FOCAL_X:  fx_q <= cfg_data_i;
        REG_FOCAL_Y:  fy_q <= cfg_data_i;
        REG_CENTER_X: cx_q <= cfg_data_i;
        REG_CENTER_Y: cy_q <= cfg_data_i;
        REG_K1:       k1_q <= cfg_data_i;
        REG_K2:       k2_q <= cfg_data_i;
        REG_P1:       p1_q <= cfg_data_i;
        REG_P2:       p2_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign k1 = QW'(k1_q);
  assign k2 = QW'(k2_q);
  assign p1 = QW'(p1_q);
  assign p2 = QW'(p2_q);

  // Pipeline-wide advance
  assign en         = !vld_q[Last] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], in_valid_i};
    end
  end

  // Normalization per axis
  ldr_divider u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .pix_i    (out_col_i),
    .focal_i  (fx_q),
    .center_i (cx_q),
    .quo_o    (x_w)
  );

  ldr_divider u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .pix_i    (out_row_i),
    .focal_i  (fy_q),
    .center_i (cy_q),
    .quo_o    (y_w)
  );

  logic signed [QW-1:0] xa_q, ya_q, xx_q, yy_q, xy_q;
  logic signed [QW-1:0] xb_q, yb_q, xxb_q, yyb_q, xyb_q, r2_q;
  logic signed [QW-1:0] xc_q, yc_q, r4_q, kr2_q, ex_q, ey_q, pa_q, pb_q;
  logic signed [QW-1:0] xd0_q, yd0_q, kr2d_q, k2r4_q, tx_q, ty_q, pad_q, pbd_q;
  logic signed [QW-1:0] xe_q, ye_q, f_q, txe_q, tye_q, pae_q, pbe_q;
  logic signed [QW-1:0] xf_q, yf_q, txf_q, tyf_q, paf_q, pbf_q;
  logic signed [QW-1:0] xd_q, yd_q;
  logic signed [56:0]   pu_q, pv_q;
  logic signed [57:0]   us, vs;
  logic                 ok;
  logic [CoordW-1:0]    col_q, row_q;
  logic                 rng_q;

  // Back projection and bounds
  always_comb begin
    us = 58'(pu_q) + $signed({14'b0, cx_q, 20'b0});
    vs = 58'(pv_q) + $signed({14'b0, cy_q, 20'b0});
    ok = (fx_q != '0) && (fy_q != '0) && !us[57] && !vs[57] &&
         (us < ColLimit) && (vs < RowLimit);
  end

  // Distortion stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // squares and cross term
      xa_q <= x_w;
      ya_q <= y_w;
      xx_q <= mulq(x_w, x_w);
      yy_q <= mulq(y_w, y_w);
      xy_q <= mulq(x_w, y_w);
      // radius squared
      xb_q  <= xa_q;
      yb_q  <= ya_q;
      xxb_q <= xx_q;
      yyb_q <= yy_q;
      xyb_q <= xy_q;
      r2_q  <= sat32(64'(xx_q) + 64'(yy_q));
      // r4, k1 term, tangential operands
      xc_q  <= xb_q;
      yc_q  <= yb_q;
      r4_q  <= mulq(r2_q, r2_q);
      kr2_q <= mulq(k1, r2_q);
      ex_q  <= sat32(64'(r2_q) + (64'(xxb_q) <<< 1));
      ey_q  <= sat32(64'(r2_q) + (64'(yyb_q) <<< 1));
      pa_q  <= mulq(p1, xyb_q);
      pb_q  <= mulq(p2, xyb_q);
      // k2 term and tangential products
      xd0_q  <= xc_q;
      yd0_q  <= yc_q;
      kr2d_q <= kr2_q;
      k2r4_q <= mulq(k2, r4_q);
      tx_q   <= mulq(p2, ex_q);
      ty_q   <= mulq(p1, ey_q);
      pad_q  <= pa_q;
      pbd_q  <= pb_q;
      // radial factor
      xe_q  <= xd0_q;
      ye_q  <= yd0_q;
      f_q   <= sat32(64'(OneQ20) + 64'(kr2d_q) + 64'(k2r4_q));
      txe_q <= tx_q;
      tye_q <= ty_q;
      pae_q <= pad_q;
      pbe_q <= pbd_q;
      // radial scaling
      xf_q  <= mulq(xe_q, f_q);
      yf_q  <= mulq(ye_q, f_q);
      txf_q <= txe_q;
      tyf_q <= tye_q;
      paf_q <= pae_q;
      pbf_q <= pbe_q;
      // distorted normalized coordinates
      xd_q <= sat32(64'(xf_q) + (64'(paf_q) <<< 1) + 64'(txf_q));
      yd_q <= sat32(64'(yf_q) + 64'(tyf_q) + (64'(pbf_q) <<< 1));
      // scale by focal length, exact in Q28
      pu_q <= $signed({1'b0, fx_q}) * xd_q;
      pv_q <= $signed({1'b0, fy_q}) * yd_q;
      // output register
      col_q <= ok ? us[28 +: CoordW] : '0;
      row_q <= ok ? vs[28 +: CoordW] : '0;
      rng_q <= ok;
    end
  end

  assign out_valid_o = vld_q[Last];
  assign src_col_o   = col_q;
  assign src_row_o   = row_q;
  assign in_range_o  = rng_q;

endmodule

@@ rtl/core/ldr_divider.sv @@
// Pipelined normalizer: ((pix*256 - center) << 20) / focal, truncated and clamped.
module ldr_divider import ldr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [CoordW-1:0]          pix_i,
  input  logic [CfgDataW-1:0]        focal_i,
  input  logic [CfgDataW-1:0]        center_i,
  output logic signed [QW-1:0]       quo_o
);

  logic [DivRemW-1:0] rem_q [0:DivSteps];
  logic [QW-1:0]      quo_q [0:DivSteps];
  logic               neg_q [0:DivSteps];
  logic signed [QW-1:0] res_q;

  logic signed [CfgDataW:0] num;
  logic [CfgDataW:0]        mag;
  logic [QW-1:0]            qsat;

  // Numerator in sign-magnitude form
  always_comb begin
    num = $signed({7'b0, pix_i, 8'b0}) - $signed({1'b0, center_i});
    mag = num[CfgDataW] ? (CfgDataW+1)'(-num) : num;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {mag[CfgDataW-1:0], FracW'(0)};
      quo_q[0] <= '0;
      neg_q[0] <= num[CfgDataW];
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    localparam int Bit = DivSteps - k;
    logic [55:0] dsr;
    logic [55:0] rem_ext;
    logic        ge;
    always_comb begin
      dsr     = 56'(focal_i) << Bit;
      rem_ext = 56'(rem_q[k-1]);
      ge      = rem_ext >= dsr;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DivRemW'(rem_ext - dsr) : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (ge ? (QW'(1) << Bit) : '0);
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Top quotient bit set means the magnitude overflowed
  assign qsat = quo_q[DivSteps][QW-1] ? SatMax : quo_q[DivSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg_q[DivSteps] ? -$signed(qsat) : $signed(qsat);
    end
  end

  assign quo_o = res_q;

endmodule

@@ rtl/core/ldr_checker.sv @@
// Port-level checker for the lens distortion remap, bound to the top level.
module ldr_checker import ldr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CoordW-1:0] src_col_o,
  input logic [CoordW-1:0] src_row_o,
  input logic              in_range_o
);

  // A waiting result stays until its transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled result payload is stable
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(src_col_o) && $stable(src_row_o) &&
    $stable(in_range_o))
    else $error("result payload changed while stalled");

  // Out-of-range results carry zero coordinates
  a_zero_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> src_col_o == '0 && src_row_o == '0)
    else $error("out-of-range result with nonzero coordinates");

  // Input side only waits on a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind lens_distortion_remap ldr_checker u_ldr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .src_col_o   (src_col_o),
  .src_row_o   (src_row_o),
  .in_range_o  (in_range_o)
);
